// ===== rtl/core/lucs_pkg.sv =====
// Shared types, constants and codes of the lenient UTF-8 character scanner.
package lucs_pkg;

  localparam int DEF_COUNTER_BITS = 32;
  localparam int CNT_OUT_BITS     = 32;
  localparam int CP_BITS          = 21;
  localparam int OP_BYTES         = 4;
  localparam int OP_CNT_BITS      = $clog2(OP_BYTES + 1);
  localparam int OP_IDX_BITS      = $clog2(OP_BYTES);
  localparam int BAD_CNT_BITS     = 5;
  localparam int OP_QUEUE_DEPTH   = 4;
  localparam int RES_QUEUE_DEPTH  = 4;
  localparam int BAD_RATIO        = 20;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BOM0  = 8'hEF;
  localparam logic [7:0] CH_BOM1  = 8'hBB;
  localparam logic [7:0] CH_BOM2  = 8'hBF;
  localparam logic [7:0] CH_FE    = 8'hFE;
  localparam logic [7:0] CH_FF    = 8'hFF;

  localparam logic [CP_BITS-1:0] CP_MIN_EMIT  = 21'd32;
  localparam logic [CP_BITS-1:0] CP_ASCII_MAX = 21'd127;

  typedef enum logic [1:0] {
    BOM_NONE,
    BOM_EF,
    BOM_EF_BB,
    BOM_UTF16
  } bom_e;

  typedef enum logic [1:0] {
    VERDICT_USABLE,
    VERDICT_INVALID,
    VERDICT_UTF16
  } verdict_e;

  typedef enum logic {
    KIND_CODE_POINT,
    KIND_VERDICT
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    kind_e                   result_kind;
    logic [CP_BITS-1:0]      code_point;
    verdict_e                verdict;
    logic [CNT_OUT_BITS-1:0] counted_bytes;
    logic [CNT_OUT_BITS-1:0] bad_sequences;
    logic                    last_result;
  } out_item_t;

  // Work handed from the front to the back: bytes to decode, then line and file ends.
  typedef struct packed {
    logic [OP_BYTES-1:0][7:0] bytes;
    logic [OP_CNT_BITS-1:0]   cnt;
    logic                     line_end;
    logic                     eof;
    logic                     abort;
  } op_t;

  // Results of one item; the verdict, when present, is the last entry.
  typedef struct packed {
    logic                    two;
    logic                    eof;
    logic                    abort;
    logic                    saw;
    logic [1:0][CP_BITS-1:0] cps;
  } grp_t;

endpackage

// ===== rtl/core/lucs_fifo.sv =====
// Small register queue used between the scanner stages.
module lucs_fifo import lucs_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = OP_QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0] count_q;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CNT_BITS'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/lucs_front.sv =====
// Front stage: line splitting, CR and byte order mark handling, comment skipping.
module lucs_front import lucs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t in_item_i,
  output logic     op_push_o,
  output op_t      op_o
);

  typedef struct packed {
    logic                     ls;
    logic                     sh;
    logic                     ic;
    logic                     ofl;
    bom_e                     bp;
    logic                     bf_ff;
    logic                     ab;
    logic [OP_CNT_BITS-1:0]   cnt;
    logic [OP_BYTES-1:0][7:0] bytes;
  } fst_t;

  logic ls_q, sh_q, cr_q, ic_q, ofl_q, bf_ff_q, ab_q;
  bom_e bp_q;
  logic cr_d, line_end;
  fst_t s;

  function automatic fst_t emit(fst_t st, logic [7:0] x);
    fst_t r;
    r = st;
    r.bytes[r.cnt[OP_IDX_BITS-1:0]] = x;
    r.cnt = r.cnt + 1'b1;
    return r;
  endfunction

  function automatic fst_t body(fst_t st, logic [7:0] x);
    fst_t r;
    r = st;
    if (r.ls && r.sh) begin
      r.sh = 1'b0;
      r.ls = 1'b0;
      if (x == CH_SLASH) begin
        r.ic = 1'b1;
      end else begin
        r = emit(r, CH_SLASH);
        r = emit(r, x);
      end
    end else if (r.ls && (x == CH_SLASH)) begin
      r.sh = 1'b1;
    end else begin
      r.ls = 1'b0;
      if (!r.ic) begin
        r = emit(r, x);
      end
    end
    return r;
  endfunction

  // Held mark bytes go back to the line as ordinary bytes.
  function automatic fst_t release_bom(fst_t st);
    fst_t r;
    bom_e p;
    r = st;
    p = r.bp;
    r.ofl = 1'b0;
    r.bp = BOM_NONE;
    unique case (p)
      BOM_EF: begin
        r = body(r, CH_BOM0);
      end
      BOM_EF_BB: begin
        r = body(r, CH_BOM0);
        r = body(r, CH_BOM1);
      end
      BOM_UTF16: begin
        r = body(r, r.bf_ff ? CH_FF : CH_FE);
      end
      BOM_NONE: begin
      end
    endcase
    r.bf_ff = 1'b0;
    return r;
  endfunction

  function automatic fst_t line_byte(fst_t st, logic [7:0] x);
    fst_t r;
    logic taken;
    r = st;
    taken = 1'b0;
    if (r.ofl) begin
      unique case (r.bp)
        BOM_NONE: begin
          if (x == CH_BOM0) begin
            r.bp = BOM_EF;
            taken = 1'b1;
          end else if ((x == CH_FF) || (x == CH_FE)) begin
            r.bp = BOM_UTF16;
            r.bf_ff = (x == CH_FF);
            taken = 1'b1;
          end else begin
            r.ofl = 1'b0;
          end
        end
        BOM_EF: begin
          if (x == CH_BOM1) begin
            r.bp = BOM_EF_BB;
            taken = 1'b1;
          end else begin
            r = release_bom(r);
          end
        end
        BOM_EF_BB: begin
          if (x == CH_BOM2) begin
            r.bp = BOM_NONE;
            r.ofl = 1'b0;
            taken = 1'b1;
          end else begin
            r = release_bom(r);
          end
        end
        BOM_UTF16: begin
          if ((r.bf_ff && (x == CH_FE)) || (!r.bf_ff && (x == CH_FF))) begin
            r.ab = 1'b1;
            r.ofl = 1'b0;
            r.bp = BOM_NONE;
            r.bf_ff = 1'b0;
            taken = 1'b1;
          end else begin
            r = release_bom(r);
          end
        end
      endcase
    end
    if (!taken) begin
      r = body(r, x);
    end
    return r;
  endfunction

  function automatic fst_t end_line(fst_t st);
    fst_t r;
    r = st;
    if (r.ofl) begin
      r = release_bom(r);
    end
    if (r.sh) begin
      r.sh = 1'b0;
      r = emit(r, CH_SLASH);
    end
    r.ofl = 1'b0;
    r.bp = BOM_NONE;
    r.ls = 1'b1;
    r.ic = 1'b0;
    return r;
  endfunction

  always_comb begin
    s = '0;
    s.ls = ls_q;
    s.sh = sh_q;
    s.ic = ic_q;
    s.ofl = ofl_q;
    s.bp = bp_q;
    s.bf_ff = bf_ff_q;
    s.ab = ab_q;
    cr_d = cr_q;
    line_end = 1'b0;
    if (in_item_i.end_of_file) begin
      if (!ab_q) begin
        cr_d = 1'b0;
        s = end_line(s);
        line_end = 1'b1;
      end
    end else if (!ab_q) begin
      if (in_item_i.data_byte == CH_LF) begin
        cr_d = 1'b0;
        s = end_line(s);
        line_end = 1'b1;
      end else begin
        if (cr_q) begin
          cr_d = 1'b0;
          s = line_byte(s, CH_CR);
        end
        if (in_item_i.data_byte == CH_CR) begin
          cr_d = 1'b1;
        end else begin
          s = line_byte(s, in_item_i.data_byte);
        end
      end
    end
  end

  always_comb begin
    op_o.bytes    = s.bytes;
    op_o.cnt      = s.cnt;
    op_o.line_end = line_end;
    op_o.eof      = in_item_i.end_of_file;
    op_o.abort    = ab_q;
    op_push_o     = accept_i && (in_item_i.end_of_file || line_end || (s.cnt != '0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ls_q    <= 1'b1;
      sh_q    <= 1'b0;
      cr_q    <= 1'b0;
      ic_q    <= 1'b0;
      ofl_q   <= 1'b1;
      bp_q    <= BOM_NONE;
      bf_ff_q <= 1'b0;
      ab_q    <= 1'b0;
    end else if (accept_i) begin
      if (in_item_i.end_of_file) begin
        ls_q    <= 1'b1;
        sh_q    <= 1'b0;
        cr_q    <= 1'b0;
        ic_q    <= 1'b0;
        ofl_q   <= 1'b1;
        bp_q    <= BOM_NONE;
        bf_ff_q <= 1'b0;
        ab_q    <= 1'b0;
      end else begin
        ls_q    <= s.ls;
        sh_q    <= s.sh;
        cr_q    <= cr_d;
        ic_q    <= s.ic;
        ofl_q   <= s.ofl;
        bp_q    <= s.bp;
        bf_ff_q <= s.bf_ff;
        ab_q    <= s.ab;
      end
    end
  end

  ap_slash_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sh_q |-> (ls_q && !ofl_q && !ic_q))
    else $error("held slash outside a fresh line");

  ap_mark_only_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ofl_q |-> (bp_q == BOM_NONE))
    else $error("mark bytes held after first line");

  ap_abort_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ab_q |-> (!cr_q && !ofl_q && !sh_q))
    else $error("line state left after UTF-16 abort");

endmodule

// ===== rtl/core/lucs_back.sv =====
// Back stage: lenient UTF-8 decoding, saturating counters and result grouping.
module lucs_back import lucs_pkg::*; #(
  parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    op_valid_i,
  input  op_t                     op_i,
  output logic                    op_pop_o,
  input  logic                    res_full_i,
  output logic                    res_push_o,
  output grp_t                    grp_o,
  output logic [COUNTER_BITS-1:0] total_o,
  output logic [COUNTER_BITS-1:0] bad_o
);

  typedef struct packed {
    logic [1:0]              pn;
    logic [1:0]              pt;
    logic [CP_BITS-1:0]      pc;
    logic [BAD_CNT_BITS-1:0] dbad;
    logic                    saw;
    logic [1:0]              ne;
    logic [1:0][CP_BITS-1:0] cps;
  } dec_t;

  logic [1:0]              pn_q, pt_q;
  logic [CP_BITS-1:0]      pc_q;
  logic [COUNTER_BITS-1:0] total_q, bad_q, total_new, bad_new;
  logic [COUNTER_BITS:0]   tsum, bsum;
  logic                    saw_q, fire, has_eof;
  logic [1:0]              n_res;
  dec_t                    d;

  function automatic dec_t give(dec_t st, logic [CP_BITS-1:0] cp);
    dec_t r;
    r = st;
    if (cp >= CP_MIN_EMIT) begin
      if (cp > CP_ASCII_MAX) begin
        r.saw = 1'b1;
      end
      if (r.ne != 2'd2) begin
        r.cps[r.ne[0]] = cp;
        r.ne = r.ne + 1'b1;
      end
    end
    return r;
  endfunction

  function automatic dec_t drop_pend(dec_t st);
    dec_t r;
    r = st;
    if (r.pn != 2'd0) begin
      r.dbad = r.dbad + BAD_CNT_BITS'(r.pt) + 1'b1;
      r.pn = 2'd0;
      r.pt = 2'd0;
      r.pc = '0;
    end
    return r;
  endfunction

  function automatic dec_t decode(dec_t st, logic [7:0] b);
    dec_t r;
    logic [CP_BITS-1:0] cp;
    r = st;
    if ((r.pn != 2'd0) && (b[7:6] == 2'b10)) begin
      r.pc = {r.pc[CP_BITS-7:0], b[5:0]};
      r.pt = r.pt + 1'b1;
      if (r.pt >= r.pn) begin
        cp = r.pc;
        r.pn = 2'd0;
        r.pt = 2'd0;
        r.pc = '0;
        r = give(r, cp);
      end
    end else begin
      r = drop_pend(r);
      if (!b[7]) begin
        r = give(r, CP_BITS'(b));
      end else if (b[7:5] == 3'b110) begin
        r.pn = 2'd1;
        r.pc = CP_BITS'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
        r.pn = 2'd2;
        r.pc = CP_BITS'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
        r.pn = 2'd3;
        r.pc = CP_BITS'(b[2:0]);
      end else begin
        r.dbad = r.dbad + 1'b1;
      end
    end
    return r;
  endfunction

  always_comb begin
    d = '0;
    d.pn = pn_q;
    d.pt = pt_q;
    d.pc = pc_q;
    d.saw = saw_q;
    for (int i = 0; i < OP_BYTES; i++) begin
      if (OP_CNT_BITS'(i) < op_i.cnt) begin
        d = decode(d, op_i.bytes[i]);
      end
    end
    if (op_i.line_end) begin
      d = drop_pend(d);
    end
  end

  assign tsum      = {1'b0, total_q} + (COUNTER_BITS + 1)'(op_i.cnt);
  assign bsum      = {1'b0, bad_q} + (COUNTER_BITS + 1)'(d.dbad);
  assign total_new = tsum[COUNTER_BITS] ? {COUNTER_BITS{1'b1}} : tsum[COUNTER_BITS-1:0];
  assign bad_new   = bsum[COUNTER_BITS] ? {COUNTER_BITS{1'b1}} : bsum[COUNTER_BITS-1:0];

  assign fire     = op_valid_i && !res_full_i;
  assign op_pop_o = fire;
  assign has_eof  = op_i.eof && (d.ne != 2'd2);
  assign n_res    = d.ne + {1'b0, has_eof};

  always_comb begin
    grp_o.two   = (n_res == 2'd2);
    grp_o.eof   = has_eof;
    grp_o.abort = op_i.abort;
    grp_o.saw   = d.saw;
    grp_o.cps   = d.cps;
    res_push_o  = fire && (n_res != 2'd0);
    total_o     = total_new;
    bad_o       = bad_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pn_q    <= 2'd0;
      pt_q    <= 2'd0;
      pc_q    <= '0;
      total_q <= '0;
      bad_q   <= '0;
      saw_q   <= 1'b0;
    end else if (fire) begin
      if (op_i.eof) begin
        pn_q    <= 2'd0;
        pt_q    <= 2'd0;
        pc_q    <= '0;
        total_q <= '0;
        bad_q   <= '0;
        saw_q   <= 1'b0;
      end else begin
        pn_q    <= d.pn;
        pt_q    <= d.pt;
        pc_q    <= d.pc;
        total_q <= total_new;
        bad_q   <= bad_new;
        saw_q   <= d.saw;
      end
    end
  end

  ap_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pn_q == 2'd0) |-> ((pt_q == 2'd0) && (pc_q == '0)))
    else $error("partial sequence left without a lead byte");

  ap_taken_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pn_q != 2'd0) |-> (pt_q < pn_q))
    else $error("continuation count reached its target");

  ap_eof_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && op_i.eof) |=> ((total_q == '0) && (bad_q == '0) && !saw_q))
    else $error("counters not cleared after end of file");

endmodule

// ===== rtl/core/lucs_out.sv =====
// Result side: walks each result group, forms the verdict and clips the counters.
module lucs_out import lucs_pkg::*; #(
  parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  grp_t                    grp_i,
  input  logic [COUNTER_BITS-1:0] total_i,
  input  logic [COUNTER_BITS-1:0] bad_i,
  input  logic                    res_empty_i,
  input  logic                    pop_i,
  output logic                    res_pop_o,
  output out_item_t               out_item_o
);

  logic                    sel_q, sel_d, last, beat, is_eof, invalid;
  logic [CNT_OUT_BITS-1:0] total_vis, bad_vis;
  logic [COUNTER_BITS+4:0] bad_scaled;
  verdict_e                verdict;

  if (COUNTER_BITS > CNT_OUT_BITS) begin : g_clip
    assign total_vis = (|total_i[COUNTER_BITS-1:CNT_OUT_BITS]) ? '1
                                                              : total_i[CNT_OUT_BITS-1:0];
    assign bad_vis   = (|bad_i[COUNTER_BITS-1:CNT_OUT_BITS]) ? '1
                                                            : bad_i[CNT_OUT_BITS-1:0];
  end else begin : g_ext
    assign total_vis = CNT_OUT_BITS'(total_i);
    assign bad_vis   = CNT_OUT_BITS'(bad_i);
  end

  // bad > total / 20 is the same as total < 20 * bad
  assign bad_scaled = (COUNTER_BITS + 5)'(bad_i) * (COUNTER_BITS + 5)'(BAD_RATIO);
  assign invalid    = (total_i != '0) &&
                      (!grp_i.saw || ((COUNTER_BITS + 5)'(total_i) < bad_scaled));

  always_comb begin
    if (grp_i.abort) begin
      verdict = VERDICT_UTF16;
    end else if (invalid) begin
      verdict = VERDICT_INVALID;
    end else begin
      verdict = VERDICT_USABLE;
    end
  end

  assign last      = !grp_i.two || sel_q;
  assign is_eof    = grp_i.eof && last;
  assign beat      = pop_i && !res_empty_i;
  assign res_pop_o = beat && last;

  always_comb begin
    sel_d = sel_q;
    if (beat) begin
      sel_d = !last;
    end
  end

  always_comb begin
    out_item_o.result_kind   = is_eof ? KIND_VERDICT : KIND_CODE_POINT;
    out_item_o.code_point    = is_eof ? '0 : grp_i.cps[sel_q];
    out_item_o.verdict       = is_eof ? verdict : VERDICT_USABLE;
    out_item_o.counted_bytes = is_eof ? total_vis : '0;
    out_item_o.bad_sequences = is_eof ? bad_vis : '0;
    out_item_o.last_result   = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

endmodule

// ===== rtl/core/lenient_utf8_char_scanner_core.sv =====
// Top level of the lenient UTF-8 character scanner.
//
// Input channel: one beat per byte of a text file (push/full), or an end item
// with end_of_file set that closes the file. Output channel (empty/pop): code
// points of 32 and above in file order, then one verdict beat per file with
// the byte and bad sequence counts. last_result marks the final beat caused
// by an input beat; an input beat may cause none, one or two results.
// Throughput: one input beat per cycle while full is low, one result beat per cycle while results wait.
// Results of an accepted input beat pass from the front into the op queue, from the decoder into
// the result queue, and from the result queue combinationally to the port.
// The end item resets all scan state, so the next file may follow at once.
// Reset clears the scan state and both queues; no result is offered.
// When pop is held low the result queue fills, the decoder waits, the op
// queue fills and full rises; nothing is lost.
module lenient_utf8_char_scanner_core import lucs_pkg::*; #(
  parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  localparam int OP_W  = $bits(op_t);
  localparam int GRP_W = $bits(grp_t);
  localparam int RES_W = GRP_W + 2 * COUNTER_BITS;

  op_t                     op_wr_s, op_rd_s;
  logic [OP_W-1:0]         op_wr, op_rd;
  logic                    op_push, op_empty, op_pop;
  grp_t                    grp_wr, grp_rd;
  logic [COUNTER_BITS-1:0] total_wr, bad_wr, total_rd, bad_rd;
  logic [RES_W-1:0]        res_wr, res_rd;
  logic                    res_push, res_full, res_pop;

  lucs_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (push && !full),
    .in_item_i (in_item_i),
    .op_push_o (op_push),
    .op_o      (op_wr_s)
  );

  assign op_wr   = op_wr_s;
  assign op_rd_s = op_t'(op_rd);

  lucs_fifo #(
    .WIDTH (OP_W),
    .DEPTH (OP_QUEUE_DEPTH)
  ) u_op_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .data_i  (op_wr),
    .full_o  (full),
    .pop_i   (op_pop),
    .data_o  (op_rd),
    .empty_o (op_empty)
  );

  lucs_back #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (!op_empty),
    .op_i       (op_rd_s),
    .op_pop_o   (op_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .grp_o      (grp_wr),
    .total_o    (total_wr),
    .bad_o      (bad_wr)
  );

  assign res_wr   = {grp_wr, total_wr, bad_wr};
  assign grp_rd   = grp_t'(res_rd[RES_W-1 -: GRP_W]);
  assign total_rd = res_rd[2*COUNTER_BITS-1 -: COUNTER_BITS];
  assign bad_rd   = res_rd[COUNTER_BITS-1:0];

  lucs_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_wr),
    .full_o  (res_full),
    .pop_i   (res_pop),
    .data_o  (res_rd),
    .empty_o (empty)
  );

  lucs_out #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_i       (grp_rd),
    .total_i     (total_rd),
    .bad_i       (bad_rd),
    .res_empty_i (empty),
    .pop_i       (pop),
    .res_pop_o   (res_pop),
    .out_item_o  (out_item_o)
  );

endmodule
